// ===== hw/rtl/hsl2rgb_pkg.sv =====
// Shared types and constants of the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;

   typedef logic [CHAN_W-1:0] chan_type;

   // Shape of the hue rule in the sector that a channel's hue falls into.
   typedef enum logic [1:0] {
      SECTOR_RISE = 2'b00,
      SECTOR_HIGH = 2'b01,
      SECTOR_FALL = 2'b10,
      SECTOR_LOW  = 2'b11
   } sector_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB color converter, a five-stage pipeline with stream ports.
`default_nettype none

// Converts one color word per clock, unless rsp_ stalls, from hue, saturation and
// lightness to 8-bit red, green and blue. Each word passes from acceptance on req_ to
// the result on rsp_ through five register stages: clamp and hue offsets with the l*s
// product, q/p and hue sector, the three sector multipliers, the channel value, and the
// byte scaling. Every stage has its own valid bit and its own ready, so a stalled rsp_
// side fills the pipeline's empty stages first and nothing is lost or repeated. Hue
// wraps at one turn; saturation and lightness above one are taken as one.
module hsl_to_rgb_converter
   import hsl2rgb_pkg::*;
#(
   parameter int FRAC_BITS = 15
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0 up: hue_turn, saturation, lightness, zero fill.
   input  wire  [8*((3*FRAC_BITS+9)/8)-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // Fields from bit 0 up: red, green, blue.
   output logic [NUM_CHAN*CHAN_W-1:0]           rsp_tdata
);

   localparam int F      = FRAC_BITS;
   localparam int SL_W   = F + 1;
   localparam int U_W    = F + 3;
   localparam int PROD_W = 2 * SL_W;
   localparam int SC_W   = SL_W + 8;

   localparam logic [SL_W-1:0] ONE_SL  = SL_W'(1) << F;
   localparam logic [SL_W-1:0] HALF_SL = ONE_SL >> 1;
   localparam logic [U_W-1:0]  ONE_U   = U_W'(1) << F;
   localparam logic [U_W-1:0]  TWO_U   = U_W'(2) << F;
   localparam logic [U_W-1:0]  THREE_U = U_W'(3) << F;
   localparam logic [U_W-1:0]  FOUR_U  = U_W'(4) << F;
   localparam logic [U_W-1:0]  SIX_U   = U_W'(6) << F;
   localparam logic [SC_W-1:0] MAX_SC  = SC_W'(255);

   // Per-stage handshake.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Stage 1: clamp, hue offsets, l*s.
   logic [F-1:0]      h_raw;
   logic [SL_W-1:0]   s_raw, l_raw, s_c, l_c;
   logic [U_W-1:0]    u_g;
   logic [U_W:0]      sum_r, sum_b;
   logic [U_W-1:0]    s1_u_in [NUM_CHAN];
   logic [PROD_W-1:0] s1_ls_in;

   logic [U_W-1:0]    s1_u_ff [NUM_CHAN];
   logic [PROD_W-1:0] s1_ls_ff;
   logic [SL_W-1:0]   s1_l_ff, s1_s_ff;
   logic              s1_grey_ff;

   always_comb begin
      h_raw = req_tdata[F-1:0];
      s_raw = req_tdata[2*F:F];
      l_raw = req_tdata[3*F+1:2*F+1];
      s_c   = (s_raw > ONE_SL) ? ONE_SL : s_raw;
      l_c   = (l_raw > ONE_SL) ? ONE_SL : l_raw;
      u_g   = (U_W'(h_raw) << 2) + (U_W'(h_raw) << 1);
      sum_r = {1'b0, u_g} + {1'b0, TWO_U};
      sum_b = {1'b0, u_g} + {1'b0, FOUR_U};
      s1_u_in[0] = (sum_r >= {1'b0, SIX_U}) ? U_W'(sum_r - {1'b0, SIX_U}) : U_W'(sum_r);
      s1_u_in[1] = u_g;
      s1_u_in[2] = (sum_b >= {1'b0, SIX_U}) ? U_W'(sum_b - {1'b0, SIX_U}) : U_W'(sum_b);
      s1_ls_in   = l_c * s_c;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_u_ff    <= s1_u_in;
         s1_ls_ff   <= s1_ls_in;
         s1_l_ff    <= l_c;
         s1_s_ff    <= s_c;
         s1_grey_ff <= (s_c == '0);
      end
   end

   // Stage 2: q, p, q-p and the hue sector of each channel.
   logic [SL_W:0]     q_lo_sum;
   logic [PROD_W:0]   big_hi;
   logic [SL_W-1:0]   q_val, q_diff;
   logic [SL_W:0]     p_w;
   logic [SL_W-1:0]   s2_q_in, s2_p_in, s2_d_in;
   sector_type        s2_kind_in [NUM_CHAN];
   logic [SL_W-1:0]   s2_t_in    [NUM_CHAN];
   logic [U_W-1:0]    fall_t     [NUM_CHAN];

   logic [SL_W-1:0]   s2_q_ff, s2_p_ff, s2_d_ff, s2_l_ff;
   sector_type        s2_kind_ff [NUM_CHAN];
   logic [SL_W-1:0]   s2_t_ff    [NUM_CHAN];
   logic              s2_grey_ff;

   always_comb begin
      q_lo_sum = {1'b0, s1_l_ff} + {1'b0, SL_W'(s1_ls_ff >> F)};
      // For lightness of one half and above, q = l + s - l*s rounded down.
      big_hi = (((PROD_W+1)'(s1_l_ff) + (PROD_W+1)'(s1_s_ff)) << F)
               - (PROD_W+1)'(s1_ls_ff);
      if (s1_l_ff < HALF_SL) begin
         q_val = q_lo_sum[SL_W-1:0];
      end else begin
         q_val = SL_W'(big_hi >> F);
      end
      p_w     = {s1_l_ff, 1'b0} - {1'b0, q_val};
      q_diff  = q_val - s1_l_ff;
      s2_q_in = q_val;
      s2_p_in = p_w[SL_W-1:0];
      // q - p equals twice q - l, which never exceeds one.
      s2_d_in = {q_diff[SL_W-2:0], 1'b0};
      for (int i = 0; i < NUM_CHAN; i++) begin
         fall_t[i] = FOUR_U - s1_u_ff[i];
         priority if (s1_u_ff[i] < ONE_U) begin
            s2_kind_in[i] = SECTOR_RISE;
            s2_t_in[i]    = SL_W'(s1_u_ff[i]);
         end else if (s1_u_ff[i] < THREE_U) begin
            s2_kind_in[i] = SECTOR_HIGH;
            s2_t_in[i]    = '0;
         end else if (s1_u_ff[i] < FOUR_U) begin
            s2_kind_in[i] = SECTOR_FALL;
            s2_t_in[i]    = SL_W'(fall_t[i]);
         end else begin
            s2_kind_in[i] = SECTOR_LOW;
            s2_t_in[i]    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_q_ff    <= s2_q_in;
         s2_p_ff    <= s2_p_in;
         s2_d_ff    <= s2_d_in;
         s2_l_ff    <= s1_l_ff;
         s2_kind_ff <= s2_kind_in;
         s2_t_ff    <= s2_t_in;
         s2_grey_ff <= s1_grey_ff;
      end
   end

   // Stage 3: one multiplier per channel for the sloped sectors.
   logic [PROD_W-1:0] s3_prod_in [NUM_CHAN];

   logic [PROD_W-1:0] s3_prod_ff [NUM_CHAN];
   sector_type        s3_kind_ff [NUM_CHAN];
   logic [SL_W-1:0]   s3_q_ff, s3_p_ff, s3_l_ff;
   logic              s3_grey_ff;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         s3_prod_in[i] = s2_d_ff * s2_t_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_prod_ff <= s3_prod_in;
         s3_kind_ff <= s2_kind_ff;
         s3_q_ff    <= s2_q_ff;
         s3_p_ff    <= s2_p_ff;
         s3_l_ff    <= s2_l_ff;
         s3_grey_ff <= s2_grey_ff;
      end
   end

   // Stage 4: channel value in Q1.F.
   logic [SL_W:0]   slope_sum [NUM_CHAN];
   logic [SL_W-1:0] s4_v_in   [NUM_CHAN];

   logic [SL_W-1:0] s4_v_ff [NUM_CHAN];
   logic            s4_grey_ff;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         slope_sum[i] = {1'b0, s3_p_ff} + {1'b0, SL_W'(s3_prod_ff[i] >> F)};
         unique case (s3_kind_ff[i])
            SECTOR_RISE: s4_v_in[i] = slope_sum[i][SL_W-1:0];
            SECTOR_FALL: s4_v_in[i] = slope_sum[i][SL_W-1:0];
            SECTOR_HIGH: s4_v_in[i] = s3_q_ff;
            SECTOR_LOW:  s4_v_in[i] = s3_p_ff;
            default:     s4_v_in[i] = s3_p_ff;
         endcase
         if (s3_grey_ff) begin
            s4_v_in[i] = s3_l_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_v_ff    <= s4_v_in;
         s4_grey_ff <= s3_grey_ff;
      end
   end

   // Stage 5: scale by 255, drop the fraction, limit to one byte.
   logic [SC_W-1:0] scaled  [NUM_CHAN];
   logic [SC_W-1:0] whole   [NUM_CHAN];
   chan_type        s5_c_in [NUM_CHAN];

   chan_type        s5_c_ff [NUM_CHAN];
   logic            s5_grey_ff;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         scaled[i]  = {s4_v_ff[i], 8'h00} - SC_W'(s4_v_ff[i]);
         whole[i]   = scaled[i] >> F;
         s5_c_in[i] = (whole[i] > MAX_SC) ? '1 : CHAN_W'(whole[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_c_ff    <= s5_c_in;
         s5_grey_ff <= s4_grey_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {s5_c_ff[2], s5_c_ff[1], s5_c_ff[0]};

`ifndef SYNTHESIS
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> v3_ff)
      else $error("stalled middle stage dropped its word");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input not ready although the output stage is empty");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && rsp_tready && !v4_ff) |=> !rsp_tvalid)
      else $error("output word repeated after it was taken");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && s5_grey_ff) |-> (s5_c_ff[0] == s5_c_ff[1] && s5_c_ff[1] == s5_c_ff[2]))
      else $error("zero saturation gave unequal channels");
`endif

endmodule

`default_nettype wire
